FILE: src/ptlm_pkg.sv
// ptlm_pkg: shared types and constants for the pre-order tree leaf merge block
// word structs for the input and result channels, opcodes, status codes, marks
package ptlm_pkg;

  localparam int MAX_NODES_DEF = 1024;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic MARK_LEAF   = 1'b0;
  localparam logic MARK_BRANCH = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic       node_is_branch;
    logic       leaf_value;
    logic [9:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        tree_bit;
    logic        mask_bit;
    logic [10:0] tree_length;
    logic [10:0] mask_length;
  } out_word_t;

endpackage

FILE: src/preorder_tree_leaf_merge_core.sv
// preorder_tree_leaf_merge_core: top level of the pre-order tree leaf merge block
// depends on ptlm_pkg and ptlm_out_buf
//
// Usage: words enter on in_valid/in_word and are taken at an edge with in_valid high
// and in_stall low; each word gives exactly one result word on out_valid/out_word,
// taken at an edge with out_valid high and out_stall low.
// Tree marks and membership bits live in two single-port-read memories with a
// registered read output; the stack tops are read back, checked and rewritten.
// Clear, branch push, full push, no-op and out-of-range read need no memory read;
// an in-range read waits for one memory read. A leaf push is written, then runs the
// three-step merge check loop once per merge (two tree reads and one mask read per
// merge) until a check fails. The result is registered in the output buffer.
// One word is in work at a time.
// Reset clears both lengths and the handshake state; the memories are not cleared,
// entries above the lengths are never used in a result.
// A stalled result waits in the output register; one more result can be held in a
// skid stage, so the next word is taken while the receiver stalls. in_stall is high
// while a word is in work and while both the output register and the skid are full.
module preorder_tree_leaf_merge_core import ptlm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(MAX_NODES);
  localparam int XW = (CW > 11) ? CW : 11;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK1 = 5'b00010,
    S_CHK2 = 5'b00100,
    S_CHK3 = 5'b01000,
    S_RDW  = 5'b10000
  } state_t;

  state_t        st_r, st_nxt;
  logic [CW-1:0] tree_cnt_r, tree_cnt_nxt;
  logic [CW-1:0] mask_cnt_r, mask_cnt_nxt;
  logic          top_mask_r, top_mask_nxt;
  logic          mlow_r, mlow_nxt;

  logic [CW-1:0] tc_m2, tc_m3, mc_m2;
  logic [XW-1:0] idx_x;
  logic          in_acc;
  logic          buf_full;

  logic          tree_mem [MAX_NODES];
  logic          mask_mem [MAX_NODES];
  logic          tree_we, mask_we;
  logic [AW-1:0] tree_waddr, mask_waddr, tree_raddr, mask_raddr;
  logic          tree_wdata, mask_wdata;
  logic          tree_q, mask_q;

  logic          res_push;
  out_word_t     res_word;

  assign in_stall = (st_r != S_IDLE) || buf_full;
  assign in_acc   = in_valid && !in_stall;
  assign tc_m2    = tree_cnt_r - CW'(2);
  assign tc_m3    = tree_cnt_r - CW'(3);
  assign mc_m2    = mask_cnt_r - CW'(2);
  assign idx_x    = XW'(in_word.read_index);

  always_comb begin
    st_nxt       = st_r;
    tree_cnt_nxt = tree_cnt_r;
    mask_cnt_nxt = mask_cnt_r;
    top_mask_nxt = top_mask_r;
    mlow_nxt     = mlow_r;
    tree_we      = 1'b0;
    mask_we      = 1'b0;
    tree_waddr   = tree_cnt_r[AW-1:0];
    mask_waddr   = mask_cnt_r[AW-1:0];
    tree_wdata   = MARK_LEAF;
    mask_wdata   = in_word.leaf_value;
    tree_raddr   = tc_m2[AW-1:0];
    mask_raddr   = mc_m2[AW-1:0];
    res_push     = 1'b0;
    res_word     = '0;
    res_word.status = ST_OK;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_word.opcode)
            OP_CLEAR: begin
              tree_cnt_nxt = '0;
              mask_cnt_nxt = '0;
              res_push     = 1'b1;
            end
            OP_PUSH: begin
              if (tree_cnt_r == CW'(MAX_NODES)) begin
                res_word.status = ST_FULL;
                res_push        = 1'b1;
              end else if (in_word.node_is_branch) begin
                tree_we      = 1'b1;
                tree_wdata   = MARK_BRANCH;
                tree_cnt_nxt = tree_cnt_r + CW'(1);
                res_push     = 1'b1;
              end else begin
                tree_we      = 1'b1;
                tree_wdata   = MARK_LEAF;
                tree_cnt_nxt = tree_cnt_r + CW'(1);
                if (mask_cnt_r != CW'(MAX_NODES)) begin
                  mask_we      = 1'b1;
                  mask_cnt_nxt = mask_cnt_r + CW'(1);
                end
                top_mask_nxt = in_word.leaf_value;
                st_nxt       = S_CHK1;
              end
            end
            OP_READ: begin
              if (idx_x >= XW'(tree_cnt_r)) begin
                res_word.status = ST_RANGE;
                res_push        = 1'b1;
              end else begin
                tree_raddr = AW'(in_word.read_index);
                mask_raddr = AW'(in_word.read_index);
                mlow_nxt   = idx_x < XW'(mask_cnt_r);
                st_nxt     = S_RDW;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_RDW: begin
        res_word.tree_bit = tree_q;
        res_word.mask_bit = mlow_r & mask_q;
        res_push          = 1'b1;
        st_nxt            = S_IDLE;
      end
      S_CHK1: begin
        if (tree_cnt_r >= CW'(3) && mask_cnt_r >= CW'(2)) begin
          st_nxt = S_CHK2;
        end else begin
          res_push = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      S_CHK2: begin
        if (tree_q == MARK_LEAF && mask_q == top_mask_r) begin
          tree_raddr = tc_m3[AW-1:0];
          st_nxt     = S_CHK3;
        end else begin
          res_push = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      S_CHK3: begin
        if (tree_q == MARK_BRANCH) begin
          tree_we      = 1'b1;
          tree_waddr   = tc_m3[AW-1:0];
          tree_wdata   = MARK_LEAF;
          tree_cnt_nxt = tc_m2;
          mask_cnt_nxt = mask_cnt_r - CW'(1);
          st_nxt       = S_CHK1;
        end else begin
          res_push = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    res_word.tree_length = 11'(tree_cnt_nxt);
    res_word.mask_length = 11'(mask_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      tree_cnt_r <= '0;
      mask_cnt_r <= '0;
    end else begin
      st_r       <= st_nxt;
      tree_cnt_r <= tree_cnt_nxt;
      mask_cnt_r <= mask_cnt_nxt;
    end
    top_mask_r <= top_mask_nxt;
    mlow_r     <= mlow_nxt;
  end

  // tree and mask stacks
  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_q <= tree_mem[tree_raddr];
  end

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    mask_q <= mask_mem[mask_raddr];
  end

  ptlm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_word (res_word),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_mask_le_tree: assert property (@(posedge clk) disable iff (!rst_n)
    mask_cnt_r <= tree_cnt_r)
    else $error("mask stack longer than tree stack");

  a_tree_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tree_cnt_r <= CW'(MAX_NODES))
    else $error("tree stack beyond capacity");

  a_merge_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHK3 && tree_q == MARK_BRANCH) |=>
      (tree_cnt_r == $past(tree_cnt_r) - CW'(2) && st_r == S_CHK1))
    else $error("merge did not shrink tree stack by two");

  a_skid_free_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !buf_full)
    else $error("skid stage full while a word is in work");

endmodule

FILE: src/ptlm_out_buf.sv
// ptlm_out_buf: result register with one skid stage for the result channel
// depends on ptlm_pkg for the result word type
module ptlm_out_buf import ptlm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t skid_word_r, skid_word_nxt;
  logic      take;

  assign take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = push;
        skid_word_nxt  = push_word;
      end else begin
        out_valid_nxt = push;
        out_word_nxt  = push_word;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
